>>> design/qpack_status_code_extractor_defines.svh
// Assertion macros used by the checker of the QPACK status code extractor.
`ifndef QPACK_STATUS_CODE_EXTRACTOR_DEFINES_SVH
`define QPACK_STATUS_CODE_EXTRACTOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define QSCE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define QSCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/qsce_pkg.sv
// Package with the parse phase and result code types of the QPACK status code extractor.
package qsce_pkg;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_LINE,
    PH_SIDX_VARINT,
    PH_NAME_VARINT,
    PH_NAME,
    PH_VAL_LEN,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    RC_OK          = 3'd0,
    RC_NOT_FOUND   = 3'd1,
    RC_PROTOCOL    = 3'd2,
    RC_UNSUPPORTED = 3'd3,
    RC_TOO_SHORT   = 3'd4
  } result_t;

  localparam logic [5:0] VARINT_SHIFT_LIMIT = 6'd56;
  localparam logic [2:0] STATUS_NAME_LEN    = 3'd7;

endpackage

>>> design/qpack_status_code_extractor.sv
// Top level of the QPACK status code extractor: byte parser and result register.
//
// One byte of a QPACK field section is taken per word, with last marking the
// final byte; one word is accepted in every cycle unless a finished result is
// waiting and the output is stalled. Each byte updates the parser state in the
// cycle it is accepted, and a section's result appears on the output in the
// cycle after its last byte. The result register is the only buffer, so the
// input stalls exactly while that register is full and its output is stalled.
module qpack_status_code_extractor
  import qsce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       last,
  input  logic       in_valid,
  output logic       in_stall,
  output logic [2:0] result_code,
  output logic [9:0] http_status,
  output logic       out_valid,
  input  logic       out_stall
);

  phase_t      phase, phase_next;
  logic        prefix_seen, prefix_seen_next;
  logic [63:0] index_accum, index_accum_next;
  logic [5:0]  varint_shift, varint_shift_next;
  logic [63:0] bytes_left, bytes_left_next;
  logic [2:0]  name_pos, name_pos_next;
  logic        name_is_status, name_is_status_next;
  logic        line_is_candidate, line_is_candidate_next;
  logic [9:0]  digit_accum, digit_accum_next;
  logic        digits_valid, digits_valid_next;
  result_t     held_result, held_result_next;
  logic [9:0]  held_status, held_status_next;

  result_t     res_code;
  logic [9:0]  res_status;
  logic        accept;

  logic [63:0] varint_sum;
  logic [63:0] bytes_dec;
  logic [63:0] name_len;
  logic [9:0]  digit_step;
  logic        is_digit;

  function automatic logic static_status_index(input logic [63:0] idx);
    return idx == 64'd24 || idx == 64'd25 || idx == 64'd63 || idx == 64'd64 ||
           idx == 64'd65 || idx == 64'd67 || idx == 64'd71;
  endfunction

  function automatic logic [7:0] status_name_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0: c = 8'h3a;
      3'd1: c = 8'h73;
      3'd2: c = 8'h74;
      3'd3: c = 8'h61;
      3'd4: c = 8'h74;
      3'd5: c = 8'h75;
      3'd6: c = 8'h73;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [9:0] indexed_status(input logic [5:0] idx);
    logic [9:0] s;
    unique case (idx)
      6'd25: s = 10'd200;
      6'd26: s = 10'd204;
      6'd27: s = 10'd206;
      6'd28: s = 10'd304;
      6'd29: s = 10'd400;
      6'd30: s = 10'd404;
      6'd31: s = 10'd500;
      default: s = 10'd0;
    endcase
    return s;
  endfunction

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign varint_sum = index_accum + ({57'd0, data_byte[6:0]} << varint_shift);
  assign bytes_dec  = bytes_left - 64'd1;
  assign is_digit   = data_byte >= 8'h30 && data_byte <= 8'h39;
  assign digit_step = (digit_accum << 3) + (digit_accum << 1) +
                      {6'd0, data_byte[3:0]};

  always_comb begin
    phase_next             = phase;
    prefix_seen_next       = prefix_seen;
    index_accum_next       = index_accum;
    varint_shift_next      = varint_shift;
    bytes_left_next        = bytes_left;
    name_pos_next          = name_pos;
    name_is_status_next    = name_is_status;
    line_is_candidate_next = line_is_candidate;
    digit_accum_next       = digit_accum;
    digits_valid_next      = digits_valid;
    held_result_next       = held_result;
    held_status_next       = held_status;
    name_len               = 64'd0;
    unique case (phase)
      PH_PREFIX: begin
        prefix_seen_next = 1'b1;
        if (prefix_seen) begin
          phase_next = PH_LINE;
        end
      end
      PH_LINE: begin
        priority if (data_byte[7:6] == 2'b11) begin
          if (data_byte[5:0] >= 6'd25 && data_byte[5:0] <= 6'd31) begin
            phase_next       = PH_DONE;
            held_result_next = RC_OK;
            held_status_next = indexed_status(data_byte[5:0]);
          end
        end else if (data_byte[7:6] == 2'b01) begin
          index_accum_next  = {60'd0, data_byte[3:0]};
          varint_shift_next = 6'd0;
          if (data_byte[3:0] == 4'hf) begin
            phase_next = PH_SIDX_VARINT;
          end else begin
            line_is_candidate_next = static_status_index({60'd0, data_byte[3:0]});
            phase_next             = PH_VAL_LEN;
          end
        end else if (data_byte[7:5] == 3'b001) begin
          index_accum_next  = {61'd0, data_byte[2:0]};
          varint_shift_next = 6'd0;
          if (data_byte[2:0] == 3'd7) begin
            phase_next = PH_NAME_VARINT;
          end else begin
            name_len            = {61'd0, data_byte[2:0]};
            bytes_left_next     = name_len;
            name_is_status_next = 1'b0;
            name_pos_next       = 3'd0;
            if (name_len == 64'd0) begin
              line_is_candidate_next = 1'b0;
              phase_next             = PH_VAL_LEN;
            end else begin
              phase_next = PH_NAME;
            end
          end
        end else begin
          phase_next       = PH_DONE;
          held_result_next = RC_UNSUPPORTED;
          held_status_next = 10'd0;
        end
      end
      PH_SIDX_VARINT: begin
        if (varint_shift > VARINT_SHIFT_LIMIT) begin
          phase_next       = PH_DONE;
          held_result_next = RC_PROTOCOL;
          held_status_next = 10'd0;
        end else begin
          index_accum_next  = varint_sum;
          varint_shift_next = varint_shift + 6'd7;
          if (!data_byte[7]) begin
            line_is_candidate_next = static_status_index(varint_sum);
            phase_next             = PH_VAL_LEN;
          end
        end
      end
      PH_NAME_VARINT: begin
        if (varint_shift > VARINT_SHIFT_LIMIT) begin
          phase_next       = PH_DONE;
          held_result_next = RC_PROTOCOL;
          held_status_next = 10'd0;
        end else begin
          index_accum_next  = varint_sum;
          varint_shift_next = varint_shift + 6'd7;
          if (!data_byte[7]) begin
            name_len            = varint_sum;
            bytes_left_next     = name_len;
            name_is_status_next = name_len == {61'd0, STATUS_NAME_LEN};
            name_pos_next       = 3'd0;
            if (name_len == 64'd0) begin
              line_is_candidate_next = 1'b0;
              phase_next             = PH_VAL_LEN;
            end else begin
              phase_next = PH_NAME;
            end
          end
        end
      end
      PH_NAME: begin
        if (name_is_status && name_pos < STATUS_NAME_LEN) begin
          if (data_byte != status_name_char(name_pos)) begin
            name_is_status_next = 1'b0;
          end
          name_pos_next = name_pos + 3'd1;
        end
        bytes_left_next = bytes_dec;
        if (bytes_dec == 64'd0) begin
          line_is_candidate_next = name_is_status_next;
          phase_next             = PH_VAL_LEN;
        end
      end
      PH_VAL_LEN: begin
        bytes_left_next        = {57'd0, data_byte[6:0]};
        line_is_candidate_next = line_is_candidate && data_byte[6:0] == 7'd3;
        digit_accum_next       = 10'd0;
        digits_valid_next      = 1'b1;
        phase_next             = (data_byte[6:0] == 7'd0) ? PH_LINE : PH_VALUE;
      end
      PH_VALUE: begin
        if (line_is_candidate) begin
          if (!is_digit) begin
            digits_valid_next = 1'b0;
          end else if (digits_valid) begin
            digit_accum_next = digit_step;
          end
        end
        bytes_left_next = bytes_dec;
        if (bytes_dec == 64'd0) begin
          if (line_is_candidate) begin
            phase_next = PH_DONE;
            if (digits_valid_next) begin
              held_result_next = RC_OK;
              held_status_next = digit_accum_next;
            end else begin
              held_result_next = RC_PROTOCOL;
              held_status_next = 10'd0;
            end
          end else begin
            phase_next = PH_LINE;
          end
        end
      end
      PH_DONE: begin
      end
    endcase
  end

  always_comb begin
    res_status = 10'd0;
    unique case (phase_next)
      PH_DONE: begin
        res_code   = held_result_next;
        res_status = (held_result_next == RC_OK) ? held_status_next : 10'd0;
      end
      PH_PREFIX: res_code = RC_TOO_SHORT;
      PH_LINE:   res_code = RC_NOT_FOUND;
      default:   res_code = RC_PROTOCOL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      phase             <= PH_PREFIX;
      prefix_seen       <= 1'b0;
      index_accum       <= 64'd0;
      varint_shift      <= 6'd0;
      bytes_left        <= 64'd0;
      name_pos          <= 3'd0;
      name_is_status    <= 1'b0;
      line_is_candidate <= 1'b0;
      digit_accum       <= 10'd0;
      digits_valid      <= 1'b1;
      held_result       <= RC_NOT_FOUND;
      held_status       <= 10'd0;
    end else if (accept) begin
      phase             <= phase_next;
      prefix_seen       <= prefix_seen_next;
      index_accum       <= index_accum_next;
      varint_shift      <= varint_shift_next;
      bytes_left        <= bytes_left_next;
      name_pos          <= name_pos_next;
      name_is_status    <= name_is_status_next;
      line_is_candidate <= line_is_candidate_next;
      digit_accum       <= digit_accum_next;
      digits_valid      <= digits_valid_next;
      held_result       <= held_result_next;
      held_status       <= held_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      result_code <= res_code;
      http_status <= res_status;
    end
  end

endmodule

>>> design/qsce_checker.sv
// Port-level checker for the QPACK status code extractor and its bind statement.
`include "qpack_status_code_extractor_defines.svh"

module qsce_checker
  import qsce_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       last,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] result_code,
  input logic [9:0] http_status,
  input logic       out_valid,
  input logic       out_stall
);

  // A status value only travels with a successful result.
  `QSCE_ASSERT_SAME(a_status_zero, clk, rst,
                    out_valid && result_code != RC_OK, http_status == 10'd0,
                    "status nonzero on a failed result")

  // The input is only held off while a result is waiting.
  `QSCE_ASSERT_SAME(a_stall_cause, clk, rst, !out_valid, !in_stall,
                    "input stalled with an empty output")

  // A new result only follows an accepted last word.
  `QSCE_ASSERT_SAME(a_result_source, clk, rst,
                    $rose(out_valid), $past(in_valid && !in_stall && last),
                    "result without a last word")

  // A stalled result holds its fields.
  `QSCE_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall,
                    out_valid && $stable(result_code) && $stable(http_status),
                    "stalled result changed")

endmodule

bind qpack_status_code_extractor qsce_checker u_qsce_checker (
  .clk         (clk),
  .rst         (rst),
  .last        (last),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .result_code (result_code),
  .http_status (http_status),
  .out_valid   (out_valid),
  .out_stall   (out_stall)
);
